// ===== rtl/core/ppts_pkg.sv =====
// ----------------------------------------------------------------------------
// ppts_pkg
// Shared types and constants of the periodic priority task scheduler: command
// codes, slot table entry layout, datapath operations and status group.
// ----------------------------------------------------------------------------
package ppts_pkg;

  localparam int DEF_MAX_SLOTS = 16;

  // width of the slot count register, the current task and the main loop code
  localparam int CNT_W = 5;

  localparam logic [CNT_W-1:0] SLOTS_RESET = 5'd16;
  localparam logic             MUTEX_RESET = 1'b1;

  localparam logic CFG_SLOTS = 1'b0;
  localparam logic CFG_MUTEX = 1'b1;

  localparam logic [2:0] CMD_TICK     = 3'd0;
  localparam logic [2:0] CMD_ADD_TASK = 3'd1;
  localparam logic [2:0] CMD_ADD_MUTEX = 3'd2;
  localparam logic [2:0] CMD_ENABLE   = 3'd3;
  localparam logic [2:0] CMD_ACQUIRE  = 3'd4;
  localparam logic [2:0] CMD_RELEASE  = 3'd5;
  localparam logic [2:0] CMD_FINISH   = 3'd6;

  typedef enum logic [1:0] {
    USE_FREE  = 2'd0,
    USE_TASK  = 2'd1,
    USE_MUTEX = 2'd2
  } usage_e;

  typedef struct packed {
    usage_e      usage;
    logic [31:0] countdown;
    logic [15:0] period;
    logic        enabled;
    logic        running;
    logic [3:0]  prio;
  } entry_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN,
    OP_PICK_RD,
    OP_PICK_WR,
    OP_SLOT_RD,
    OP_SLOT_WR,
    OP_CUR_RD,
    OP_CUR_WR,
    OP_RESULT
  } dp_op_e;

  typedef struct packed {
    logic [2:0]       cmd;
    logic             slot_ok;
    logic             cur_ok;
    logic             acq_go;
    logic             out_free;
    logic [CNT_W-1:0] n_eff;
  } dp_sts_t;

endpackage

// ===== rtl/core/periodic_priority_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// periodic_priority_task_scheduler
// Fixed-priority periodic task scheduler with priority ceiling mutexes.
//
// Input channel (in_valid_i / in_stall_o) carries one command beat: tick, add
// task, add mutex, enable task, acquire, release or task finished. Every beat
// yields exactly one result beat on the output channel (out_valid_o /
// out_stall_i): accepted flag, running task, main loop flag, fresh start.
// Commands are processed one at a time. A tick walks the effective slots of
// the table one slot per cycle through the single table read port. The next
// beat is taken as soon as the previous one is finished, while its result may
// still sit in the output register.
// If the receiver stalls, the result is held in the output register; a second
// finished result waits in the sequencer, and in_stall_o stays high.
// Reset frees all slots, selects the main loop, sets the slot count to 16 and
// enables mutexes. Configuration is written through cfg_we_i / cfg_idx_i /
// cfg_wdata_i while the block is idle, which the user must ensure.
// ----------------------------------------------------------------------------
module periodic_priority_task_scheduler import ppts_pkg::*; #(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [2:0]       cmd_i,
  input  logic [3:0]       slot_i,
  input  logic [15:0]      task_period_i,
  input  logic             enable_flag_i,
  input  logic [15:0]      elapsed_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             accepted_o,
  output logic [CNT_W-1:0] running_task_o,
  output logic             main_loop_o,
  output logic             fresh_start_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CNT_W-1:0] cfg_wdata_i
);

  localparam int SLOT_W = $clog2(MAX_SLOTS);

  dp_op_e            op;
  dp_sts_t           sts;
  logic [SLOT_W-1:0] idx;

  ppts_ctrl #(
    .MAX_SLOTS (MAX_SLOTS),
    .SLOT_W    (SLOT_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .op_o       (op),
    .idx_o      (idx)
  );

  ppts_dpath #(
    .MAX_SLOTS (MAX_SLOTS),
    .SLOT_W    (SLOT_W)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op),
    .idx_i          (idx),
    .sts_o          (sts),
    .cmd_i          (cmd_i),
    .slot_i         (slot_i),
    .task_period_i  (task_period_i),
    .enable_flag_i  (enable_flag_i),
    .elapsed_i      (elapsed_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .accepted_o     (accepted_o),
    .running_task_o (running_task_o),
    .main_loop_o    (main_loop_o),
    .fresh_start_o  (fresh_start_o)
  );

endmodule

// ===== rtl/core/ppts_dpath.sv =====
// ----------------------------------------------------------------------------
// ppts_dpath
// Slot table memory, configuration registers, current task, scan best-pick
// tracking and the output register of the scheduler.
// ----------------------------------------------------------------------------
module ppts_dpath import ppts_pkg::*; #(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS,
  parameter int SLOT_W    = $clog2(MAX_SLOTS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_op_e            op_i,
  input  logic [SLOT_W-1:0] idx_i,
  output dp_sts_t           sts_o,
  input  logic [2:0]        cmd_i,
  input  logic [3:0]        slot_i,
  input  logic [15:0]       task_period_i,
  input  logic              enable_flag_i,
  input  logic [15:0]       elapsed_i,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CNT_W-1:0]  cfg_wdata_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              accepted_o,
  output logic [CNT_W-1:0]  running_task_o,
  output logic              main_loop_o,
  output logic              fresh_start_o
);

  logic [CNT_W-1:0]  slots_q;
  logic              mutex_q;
  logic [2:0]        cmd_q;
  logic [3:0]        slot_q;
  logic [15:0]       period_q;
  logic              en_q;
  logic [15:0]       elapsed_q;
  logic [CNT_W-1:0]  current_q;

  entry_t            mem [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] vld_q;
  entry_t            rdata_q;
  logic              rvld_q;
  entry_t            rentry;

  logic [SLOT_W-1:0] raddr;
  logic [SLOT_W-1:0] waddr;
  logic              we;
  entry_t            wentry;

  logic [SLOT_W-1:0] best_q;
  logic [CNT_W-1:0]  best_prio_q;
  logic              best_found_q;
  logic              proc_q;
  logic [SLOT_W-1:0] proc_addr_q;
  logic              acc_q;
  logic              fresh_q;

  logic              out_valid_q;
  logic              out_acc_q;
  logic [CNT_W-1:0]  out_rt_q;
  logic              out_ml_q;
  logic              out_fresh_q;

  logic [CNT_W-1:0]  n_eff;
  logic              slot_ok;
  logic              cur_ok;
  logic              main_loop;
  logic [SLOT_W-1:0] slot_idx;
  logic [SLOT_W-1:0] cur_idx;
  logic [32:0]       sub;
  logic [31:0]       cd_sub;
  logic [32:0]       add;
  logic [31:0]       cd_add;
  logic              cand;

  always_comb begin
    if (slots_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(slots_q) > MAX_SLOTS) begin
      n_eff = CNT_W'(MAX_SLOTS);
    end else begin
      n_eff = slots_q;
    end
  end

  assign slot_ok   = {1'b0, slot_q} < n_eff;
  assign cur_ok    = current_q < n_eff;
  assign main_loop = !cur_ok;
  assign slot_idx  = SLOT_W'(slot_q);
  assign cur_idx   = SLOT_W'(current_q);
  assign rentry    = rvld_q ? rdata_q : entry_t'('0);

  assign sub    = {rentry.countdown[31], rentry.countdown} - {17'd0, elapsed_q};
  assign cd_sub = (sub[32] != sub[31]) ? 32'h8000_0000 : sub[31:0];
  assign add    = {rentry.countdown[31], rentry.countdown} + {17'd0, rentry.period};
  assign cd_add = (add[32] != add[31]) ? 32'h7FFF_FFFF : add[31:0];

  assign cand = proc_q && (rentry.usage == USE_TASK) && rentry.enabled &&
                (cd_sub[31] || (cd_sub == '0)) && ({1'b0, rentry.prio} < best_prio_q);

  assign sts_o.cmd      = cmd_q;
  assign sts_o.slot_ok  = slot_ok;
  assign sts_o.cur_ok   = cur_ok;
  assign sts_o.acq_go   = (rentry.usage == USE_MUTEX) && mutex_q && cur_ok;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign sts_o.n_eff    = n_eff;

  always_comb begin
    raddr  = idx_i;
    we     = 1'b0;
    waddr  = slot_idx;
    wentry = rentry;
    if (proc_q && (rentry.usage == USE_TASK)) begin
      we               = 1'b1;
      waddr            = proc_addr_q;
      wentry.countdown = cd_sub;
    end
    unique case (op_i)
      OP_PICK_RD: raddr = best_q;
      OP_SLOT_RD: raddr = slot_idx;
      OP_CUR_RD:  raddr = cur_idx;
      OP_PICK_WR: begin
        if (best_found_q) begin
          we               = 1'b1;
          waddr            = best_q;
          wentry.countdown = cd_add;
          wentry.running   = 1'b1;
        end
      end
      OP_SLOT_WR: begin
        unique case (cmd_q)
          CMD_ADD_TASK: begin
            we               = 1'b1;
            wentry.usage     = USE_TASK;
            wentry.countdown = {16'd0, period_q};
            wentry.period    = period_q;
            wentry.enabled   = 1'b1;
            wentry.running   = 1'b0;
            wentry.prio      = slot_q;
          end
          CMD_ADD_MUTEX: begin
            we           = 1'b1;
            wentry.usage = USE_MUTEX;
          end
          CMD_ENABLE: begin
            we             = (rentry.usage == USE_TASK);
            wentry.enabled = en_q;
          end
          default: ;
        endcase
      end
      OP_CUR_WR: begin
        we    = 1'b1;
        waddr = cur_idx;
        unique case (cmd_q)
          CMD_ACQUIRE: wentry.prio    = slot_q;
          CMD_RELEASE: wentry.prio    = 4'(current_q);
          CMD_FINISH:  wentry.running = 1'b0;
          default:     we             = 1'b0;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wentry;
    end
    rdata_q <= mem[raddr];
    rvld_q  <= vld_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q     <= SLOTS_RESET;
      mutex_q     <= MUTEX_RESET;
      vld_q       <= '0;
      current_q   <= SLOTS_RESET;
      out_valid_q <= 1'b0;
      proc_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SLOTS: slots_q <= cfg_wdata_i;
          CFG_MUTEX: mutex_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
      if (op_i == OP_PICK_WR) begin
        current_q <= best_found_q ? CNT_W'(best_q) : n_eff;
      end
      proc_q <= (op_i == OP_SCAN);
      if (op_i == OP_RESULT) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    proc_addr_q <= idx_i;
    if (cand) begin
      best_q       <= proc_addr_q;
      best_prio_q  <= {1'b0, rentry.prio};
      best_found_q <= 1'b1;
    end
    unique case (op_i)
      OP_LOAD: begin
        cmd_q        <= cmd_i;
        slot_q       <= slot_i;
        period_q     <= task_period_i;
        en_q         <= enable_flag_i;
        elapsed_q    <= elapsed_i;
        acc_q        <= 1'b0;
        fresh_q      <= 1'b0;
        best_prio_q  <= n_eff;
        best_found_q <= 1'b0;
      end
      OP_PICK_WR: begin
        acc_q   <= 1'b1;
        fresh_q <= best_found_q && !rentry.running;
      end
      OP_SLOT_WR: begin
        if ((cmd_q == CMD_ADD_TASK) || (cmd_q == CMD_ADD_MUTEX) ||
            ((cmd_q == CMD_ENABLE) && (rentry.usage == USE_TASK))) begin
          acc_q <= 1'b1;
        end
      end
      OP_CUR_WR: acc_q <= 1'b1;
      OP_RESULT: begin
        out_acc_q   <= acc_q;
        out_rt_q    <= main_loop ? n_eff : current_q;
        out_ml_q    <= main_loop;
        out_fresh_q <= fresh_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign accepted_o     = out_acc_q;
  assign running_task_o = out_rt_q;
  assign main_loop_o    = out_ml_q;
  assign fresh_start_o  = out_fresh_q;

endmodule

// ===== rtl/core/ppts_ctrl.sv =====
// ----------------------------------------------------------------------------
// ppts_ctrl
// Command sequencer of the scheduler: decodes each beat, walks the slot table
// on a tick and orders the table reads and writes of the other commands.
// ----------------------------------------------------------------------------
module ppts_ctrl import ppts_pkg::*; #(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS,
  parameter int SLOT_W    = $clog2(MAX_SLOTS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dp_sts_t           sts_i,
  output dp_op_e            op_o,
  output logic [SLOT_W-1:0] idx_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_SCAN_END,
    ST_PICK_RD,
    ST_PICK_WR,
    ST_SLOT_RD,
    ST_SLOT_WR,
    ST_CUR_RD,
    ST_CUR_WR,
    ST_DONE
  } state_e;

  state_e            state_q;
  logic [SLOT_W-1:0] idx_q;
  logic              scan_last;

  assign in_stall_o = (state_q != ST_IDLE);
  assign idx_o      = idx_q;
  assign scan_last  = (CNT_W'(idx_q) == (sts_i.n_eff - CNT_W'(1)));

  always_comb begin
    unique case (state_q)
      ST_IDLE:     op_o = in_valid_i ? OP_LOAD : OP_NONE;
      ST_SCAN:     op_o = OP_SCAN;
      ST_PICK_RD:  op_o = OP_PICK_RD;
      ST_PICK_WR:  op_o = OP_PICK_WR;
      ST_SLOT_RD:  op_o = OP_SLOT_RD;
      ST_SLOT_WR:  op_o = OP_SLOT_WR;
      ST_CUR_RD:   op_o = OP_CUR_RD;
      ST_CUR_WR:   op_o = OP_CUR_WR;
      ST_DONE:     op_o = sts_i.out_free ? OP_RESULT : OP_NONE;
      default:     op_o = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          idx_q <= '0;
          unique case (sts_i.cmd)
            CMD_TICK: state_q <= ST_SCAN;
            CMD_ADD_TASK, CMD_ADD_MUTEX, CMD_ENABLE, CMD_ACQUIRE:
              state_q <= sts_i.slot_ok ? ST_SLOT_RD : ST_DONE;
            CMD_RELEASE, CMD_FINISH:
              state_q <= sts_i.cur_ok ? ST_CUR_RD : ST_DONE;
            default: state_q <= ST_DONE;
          endcase
        end
        ST_SCAN: begin
          if (scan_last) begin
            state_q <= ST_SCAN_END;
          end else begin
            idx_q <= idx_q + SLOT_W'(1);
          end
        end
        ST_SCAN_END: state_q <= ST_PICK_RD;
        ST_PICK_RD:  state_q <= ST_PICK_WR;
        ST_PICK_WR:  state_q <= ST_DONE;
        ST_SLOT_RD:  state_q <= ST_SLOT_WR;
        ST_SLOT_WR: begin
          if ((sts_i.cmd == CMD_ACQUIRE) && sts_i.acq_go) begin
            state_q <= ST_CUR_RD;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_CUR_RD:   state_q <= ST_CUR_WR;
        ST_CUR_WR:   state_q <= ST_DONE;
        ST_DONE: begin
          if (sts_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
